@@ rtl/bepd_pkg.sv @@
package bepd_pkg;

  // primitive kind codes
  localparam logic [3:0] KIND_BOOL = 4'd0;
  localparam logic [3:0] KIND_I8   = 4'd1;
  localparam logic [3:0] KIND_U8   = 4'd2;
  localparam logic [3:0] KIND_I16  = 4'd3;
  localparam logic [3:0] KIND_U16  = 4'd4;
  localparam logic [3:0] KIND_I32  = 4'd5;
  localparam logic [3:0] KIND_U32  = 4'd6;
  localparam logic [3:0] KIND_I64  = 4'd7;
  localparam logic [3:0] KIND_U64  = 4'd8;
  localparam logic [3:0] KIND_F32  = 4'd9;
  localparam logic [3:0] KIND_F64  = 4'd10;

  // value classes
  localparam logic [1:0] CLS_SIGNED   = 2'd0;
  localparam logic [1:0] CLS_UNSIGNED = 2'd1;
  localparam logic [1:0] CLS_FLOAT    = 2'd2;

  // decoded item carried down the pipe
  typedef struct packed {
    logic        ok;
    logic [3:0]  width;
    logic [1:0]  cls;
    logic [63:0] exact;
    logic        is_int;
    logic        neg;
    logic [63:0] mag;
    logic [63:0] fbits;
  } dec_t;

  // leading-one position of a 64-bit word (0 for zero)
  function automatic logic [5:0] top_bit64(input logic [63:0] m);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage

@@ rtl/bepd_i2d.sv @@
// Integer to double, round to nearest even, over three register stages:
// leading-one search, normalizing shift, round and pack.
module bepd_i2d (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic        in_neg,
  input  logic [63:0] in_mag,
  output logic        out_vld,
  output logic [63:0] out_bits
);
  import bepd_pkg::*;

  // stage 1: leading-one
  logic        s1_vld_r, s1_neg_r, s1_zero_r;
  logic [63:0] s1_mag_r;
  logic [5:0]  s1_p_r;
  // stage 2: normalized mantissa, sticky
  logic        s2_vld_r, s2_neg_r, s2_zero_r;
  logic [5:0]  s2_p_r;
  logic [52:0] s2_keep_r;
  logic        s2_g_r, s2_s_r;
  // stage 3: packed result
  logic        s3_vld_r;
  logic [63:0] s3_bits_r;

  logic [63:0] norm;
  logic [53:0] rnd;
  logic [10:0] expo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  // leading-one search
  always_ff @(posedge clk) begin
    s1_neg_r  <= in_neg;
    s1_zero_r <= (in_mag == 64'd0);
    s1_mag_r  <= in_mag;
    s1_p_r    <= top_bit64(in_mag);
  end

  // left-justify: top one lands in bit 63
  assign norm = s1_mag_r << (6'd63 - s1_p_r);

  always_ff @(posedge clk) begin
    s2_neg_r  <= s1_neg_r;
    s2_zero_r <= s1_zero_r;
    s2_p_r    <= s1_p_r;
    s2_keep_r <= norm[63:11];
    s2_g_r    <= norm[10];
    s2_s_r    <= |norm[9:0];
  end

  // round to nearest even, carry bumps the exponent
  assign rnd  = {1'b0, s2_keep_r} +
                54'(s2_g_r & (s2_s_r | s2_keep_r[0]));
  assign expo = 11'd1023 + 11'(s2_p_r) + 11'(rnd[53]);

  always_ff @(posedge clk) begin
    if (s2_zero_r) s3_bits_r <= 64'd0;
    else if (rnd[53]) s3_bits_r <= {s2_neg_r, expo, rnd[52:1]};
    else s3_bits_r <= {s2_neg_r, expo, rnd[51:0]};
  end

  assign out_vld  = s3_vld_r;
  assign out_bits = s3_bits_r;

  // a rounding carry only comes from an all-ones mantissa
  a_carry: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r && rnd[53] |-> (&s2_keep_r))
    else $error("rounding carry without full mantissa");
  a_vld: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> ##2 s3_vld_r)
    else $error("valid lost in i2d");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && s1_zero_r |-> ##2 (s3_bits_r == 64'd0))
    else $error("zero did not give +0.0");
endmodule

@@ rtl/big_endian_primitive_to_double_top.sv @@
// Channel | Ports                                   | Transfer
// input   | start, busy, in_command, in_raw_bytes   | start && !busy
// result  | out_strobe, out_* fields                | out_strobe (one cycle)
//
// One item per cycle; every item gives one result after its transfer,
// registered through the decode stage and the three stages of the integer-to-double unit.
// busy stays low: the receiver cannot stall, so nothing ever backs up.
// Reset (synchronous, rst_n low) clears only the valid bits of the pipe.
module big_endian_primitive_to_double_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_command,
  input  logic [63:0] in_raw_bytes,
  output logic        out_strobe,
  output logic        out_decode_ok,
  output logic [3:0]  out_byte_width,
  output logic [1:0]  out_value_class,
  output logic [63:0] out_exact_value,
  output logic [63:0] out_double_bits
);
  import bepd_pkg::*;

  dec_t d_nxt, d_r;
  dec_t p1_r, p2_r, p3_r;
  logic d_vld_r;
  logic i_vld;
  logic [63:0] i_bits;

  assign busy = 1'b0;

  // float32 widening (used for kind f32)
  function automatic logic [63:0] widen(input logic [31:0] b);
    logic [5:0] p;
    logic [63:0] fr;
    p = top_bit64({41'd0, b[22:0]});
    fr = {41'd0, b[22:0]} << (6'd52 - p);
    if (b[30:23] == 8'hFF) begin
      if (b[22:0] == 23'd0) return {b[31], 11'h7FF, 52'd0};
      // NaN: payload to the top of the fraction, quiet bit forced
      return {b[31], 11'h7FF, 1'b1, b[21:0], 29'd0};
    end
    if (b[30:23] == 8'd0) begin
      if (b[22:0] == 23'd0) return {b[31], 63'd0};
      return {b[31], 11'(11'd874 + 11'(p)), fr[51:0]};
    end
    return {b[31], 11'(b[30:23]) + 11'd896, b[22:0], 29'd0};
  endfunction

  // decode stage: width, class, extension
  always_comb begin
    d_nxt = '0;
    d_nxt.ok = 1'b1;
    d_nxt.is_int = 1'b1;
    case (in_command)
      KIND_BOOL: begin
        d_nxt.width = 4'd1; d_nxt.cls = CLS_UNSIGNED;
        d_nxt.exact = {63'd0, |in_raw_bytes[63:56]};
      end
      KIND_I8: begin
        d_nxt.width = 4'd1; d_nxt.cls = CLS_SIGNED;
        d_nxt.exact = {{56{in_raw_bytes[63]}}, in_raw_bytes[63:56]};
      end
      KIND_U8: begin
        d_nxt.width = 4'd1; d_nxt.cls = CLS_UNSIGNED;
        d_nxt.exact = {56'd0, in_raw_bytes[63:56]};
      end
      KIND_I16: begin
        d_nxt.width = 4'd2; d_nxt.cls = CLS_SIGNED;
        d_nxt.exact = {{48{in_raw_bytes[63]}}, in_raw_bytes[63:48]};
      end
      KIND_U16: begin
        d_nxt.width = 4'd2; d_nxt.cls = CLS_UNSIGNED;
        d_nxt.exact = {48'd0, in_raw_bytes[63:48]};
      end
      KIND_I32: begin
        d_nxt.width = 4'd4; d_nxt.cls = CLS_SIGNED;
        d_nxt.exact = {{32{in_raw_bytes[63]}}, in_raw_bytes[63:32]};
      end
      KIND_U32: begin
        d_nxt.width = 4'd4; d_nxt.cls = CLS_UNSIGNED;
        d_nxt.exact = {32'd0, in_raw_bytes[63:32]};
      end
      KIND_I64: begin
        d_nxt.width = 4'd8; d_nxt.cls = CLS_SIGNED;
        d_nxt.exact = in_raw_bytes;
      end
      KIND_U64: begin
        d_nxt.width = 4'd8; d_nxt.cls = CLS_UNSIGNED;
        d_nxt.exact = in_raw_bytes;
      end
      KIND_F32: begin
        d_nxt.width = 4'd4; d_nxt.cls = CLS_FLOAT; d_nxt.is_int = 1'b0;
        d_nxt.exact = widen(in_raw_bytes[63:32]);
      end
      KIND_F64: begin
        d_nxt.width = 4'd8; d_nxt.cls = CLS_FLOAT; d_nxt.is_int = 1'b0;
        d_nxt.exact = in_raw_bytes;
      end
      default: begin
        d_nxt.ok = 1'b0; d_nxt.is_int = 1'b0;
      end
    endcase
    d_nxt.neg = (d_nxt.cls == CLS_SIGNED) && d_nxt.is_int && d_nxt.exact[63];
    d_nxt.mag = d_nxt.neg ? (64'd0 - d_nxt.exact) : d_nxt.exact;
    d_nxt.fbits = d_nxt.exact;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) d_vld_r <= 1'b0;
    else d_vld_r <= start && !busy;
  end

  // decode register, then side pipe matching the converter latency
  always_ff @(posedge clk) begin
    d_r  <= d_nxt;
    p1_r <= d_r;
    p2_r <= p1_r;
    p3_r <= p2_r;
  end

  bepd_i2d u_i2d (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (d_vld_r),
    .in_neg   (d_r.neg),
    .in_mag   (d_r.mag),
    .out_vld  (i_vld),
    .out_bits (i_bits)
  );

  assign out_strobe      = i_vld;
  assign out_decode_ok   = p3_r.ok;
  assign out_byte_width  = p3_r.width;
  assign out_value_class = p3_r.cls;
  assign out_exact_value = p3_r.exact;
  assign out_double_bits = p3_r.is_int ? i_bits : p3_r.fbits;

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##4 out_strobe)
    else $error("result did not follow transfer");
  a_unk: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_decode_ok |-> out_byte_width == 4'd0 && out_exact_value == 64'd0)
    else $error("unknown kind left data");
  a_flt: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_value_class == CLS_FLOAT |-> out_double_bits == out_exact_value)
    else $error("float class mismatch");
endmodule
